>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, constants and the key compare for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_PEEK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } spq_ctrl_t;

    function automatic logic key_le(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
        return a <= b;
    endfunction

endpackage

>>> rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded queue of signed keys kept in descending order in a chain of cells
// ----------------------------------------------------------------------------
// sequence: after start is taken the queue compares, then updates the chain,
// and done pulses from a register set in the update state; a new start is
// taken only while busy is low; busy is high in the compare and update states
// reset: the queue comes up empty, busy and done low
// results are not held: done marks a one-cycle result with no back-pressure
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [1:0]              mode,
    input  logic signed [KEY_W-1:0] value,
    output logic                    busy,
    output logic                    done,
    output logic                    success,
    output logic signed [KEY_W-1:0] head_value,
    output logic                    head_valid,
    output logic [COUNT_W-1:0]      count,
    output logic                    full_res
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t                  state_reg;
    state_t                  state_next;
    mode_t                   mode_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    success_reg;
    logic                    success_next;
    logic                    done_reg;
    spq_ctrl_t               ctrl;
    logic                    full;
    logic                    found;

    logic signed [KEY_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]     cell_valid;
    logic [CAPACITY-1:0]     cell_ge;
    logic [CAPACITY-1:0]     cell_eq;

    assign full  = (count_reg == CW'(CAPACITY));
    assign found = |cell_eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= (state_reg == ST_UPD);
            success_reg <= success_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode_t'(mode);
            key_reg  <= value;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        success_next = success_reg;
        ctrl         = '0;
        busy         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                busy       = 1'b1;
                ctrl.cmp   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                busy       = 1'b1;
                state_next = ST_IDLE;
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        ctrl.ins     = !full;
                        success_next = !full;
                        if (!full)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        ctrl.rem     = found;
                        success_next = found;
                        if (found)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    MODE_FIND:
                    begin
                        success_next = found;
                    end
                    MODE_PEEK:
                    begin
                        success_next = (count_reg != '0);
                    end
                    default:
                    begin
                        success_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] prev_value;
        logic                    prev_valid;
        logic                    prev_ge;
        logic signed [KEY_W-1:0] next_value;
        logic                    next_valid;

        if (i == 0)
        begin : g_head
            assign prev_value = '0;
            assign prev_valid = 1'b0;
            assign prev_ge    = 1'b0;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_ge    = cell_ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_ge    (prev_ge),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .ge         (cell_ge[i]),
            .eq         (cell_eq[i])
        );
    end

    assign done       = done_reg;
    assign success    = success_reg;
    assign head_valid = cell_valid[0];
    assign head_value = cell_valid[0] ? cell_value[0] : '0;
    assign count      = COUNT_W'(count_reg);
    assign full_res   = full;

endmodule

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares it with the key and
// takes a neighbor's entry when the chain shifts
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  spq_ctrl_t               ctrl,
    input  logic signed [KEY_W-1:0] key,
    input  logic signed [KEY_W-1:0] prev_value,
    input  logic                    prev_valid,
    input  logic                    prev_ge,
    input  logic signed [KEY_W-1:0] next_value,
    input  logic                    next_valid,
    output logic signed [KEY_W-1:0] value,
    output logic                    valid,
    output logic                    ge,
    output logic                    eq
);

    logic signed [KEY_W-1:0] value_reg;
    logic signed [KEY_W-1:0] value_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    ge_reg;
    logic                    eq_reg;

    // slot is at or past the insert point: empty, or entry not above the key
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            ge_reg <= !valid_reg || key_le(value_reg, key);
            eq_reg <= valid_reg && (value_reg == key);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            if (prev_ge)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else if (ge_reg)
            begin
                value_next = key;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.rem && ge_reg)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

>>> tb/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// drives insert, remove, find and peek items into the sorted priority queue
// and compares every result with a behavioral queue kept in the testbench, or for some
// directed rows with a status written in the table; a short directed table covers empty,
// full, extreme and duplicate keys, then random items alternate fill-heavy and drain-heavy phases with random gaps
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_LO     = 600;
    localparam int QUIET_HI     = 900;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

    typedef struct packed {
        logic                    success;
        logic signed [KEY_W-1:0] head_value;
        logic                    head_valid;
        logic [COUNT_W-1:0]      count;
        logic                    full_res;
    } queue_status_t;

    typedef struct packed {
        mode_t                   op;
        logic signed [KEY_W-1:0] key;
        logic                    typed;
        queue_status_t           status;
    } queue_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [1:0]              mode = 2'd0;
    logic signed [KEY_W-1:0] value = '0;
    logic                    busy;
    logic                    done;
    logic                    success;
    logic signed [KEY_W-1:0] head_value;
    logic                    head_valid;
    logic [COUNT_W-1:0]      count;
    logic                    full_res;

    logic signed [KEY_W-1:0] held_keys [SPQ_CAPACITY];
    int                      held = 0;

    queue_item_t   table_rows [$];
    queue_status_t status_fifo [$];
    queue_item_t   cur;
    queue_status_t want;
    queue_status_t got;
    int            row_idx = 0;
    int            rand_idx = 0;
    int            items_sent = 0;
    int            total_items = 0;
    int            gap = 0;
    int            cycles = 0;
    int            errors = 0;
    bit            presenting = 1'b0;

    sorted_priority_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .value      (value),
        .busy       (busy),
        .done       (done),
        .success    (success),
        .head_value (head_value),
        .head_valid (head_valid),
        .count      (count),
        .full_res   (full_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int slot_of(logic signed [KEY_W-1:0] k);
        int i;
        for (i = 0; i < held; i++)
        begin
            if (held_keys[i] == k)
                return i;
        end
        return held;
    endfunction

    function automatic queue_status_t apply_op(mode_t op, logic signed [KEY_W-1:0] k);
        queue_status_t s;
        int pos;
        s = '0;
        case (op)
            MODE_INSERT:
            begin
                if (held < SPQ_CAPACITY)
                begin
                    pos = 0;
                    while (pos < held && held_keys[pos] > k)
                        pos++;
                    for (int i = held; i > pos; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[pos] = k;
                    held++;
                    s.success = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                pos = slot_of(k);
                if (pos < held)
                begin
                    for (int i = pos; i < held - 1; i++)
                        held_keys[i] = held_keys[i+1];
                    held--;
                    s.success = 1'b1;
                end
            end
            MODE_FIND:
                s.success = slot_of(k) < held;
            default:
                s.success = held > 0;
        endcase
        s.head_value = (held > 0) ? held_keys[0] : '0;
        s.head_valid = held > 0;
        s.count      = COUNT_W'(held);
        s.full_res   = held == SPQ_CAPACITY;
        return s;
    endfunction

    function automatic queue_item_t random_item();
        queue_item_t it;
        int r;
        bit fill;
        it = '0;
        r = $urandom_range(0, 99);
        fill = ((rand_idx / 80) % 2) == 0;
        if (fill)
            it.op = (r < 60) ? MODE_INSERT : (r < 75) ? MODE_REMOVE :
                    (r < 90) ? MODE_FIND : MODE_PEEK;
        else
            it.op = (r < 15) ? MODE_INSERT : (r < 70) ? MODE_REMOVE :
                    (r < 88) ? MODE_FIND : MODE_PEEK;
        if ((it.op == MODE_REMOVE || it.op == MODE_FIND) && held > 0 &&
            $urandom_range(0, 9) < 7)
            it.key = held_keys[$urandom_range(0, held - 1)];
        else
        begin
            case ($urandom_range(0, 9))
                0:       it.key = KEY_MAX;
                1:       it.key = KEY_MIN;
                2, 3, 4, 5:
                         it.key = $signed($urandom_range(0, 8)) - 4;
                default: it.key = $urandom;
            endcase
        end
        return it;
    endfunction

    task automatic add_row(mode_t op, logic signed [KEY_W-1:0] k, logic typed,
                           queue_status_t s);
        queue_item_t it;
        it.op     = op;
        it.key    = k;
        it.typed  = typed;
        it.status = s;
        table_rows.push_back(it);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (done)
            begin
                if (status_fifo.size() == 0)
                begin
                    $error("result with no item pending");
                    errors++;
                end
                else
                begin
                    want = status_fifo.pop_front();
                    if (success !== want.success)
                    begin
                        $error("success: expected %0d actual %0d", want.success, success);
                        errors++;
                    end
                    if (head_value !== want.head_value)
                    begin
                        $error("head_value: expected %0d actual %0d",
                               want.head_value, head_value);
                        errors++;
                    end
                    if (head_valid !== want.head_valid)
                    begin
                        $error("head_valid: expected %0d actual %0d",
                               want.head_valid, head_valid);
                        errors++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d actual %0d", want.count, count);
                        errors++;
                    end
                    if (full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0d actual %0d", want.full_res, full_res);
                        errors++;
                    end
                end
            end

            if (start && !busy)
            begin
                got = apply_op(cur.op, cur.key);
                status_fifo.push_back(cur.typed ? cur.status : got);
                items_sent++;
                presenting = 1'b0;
                gap = 0;
                if (items_sent < total_items && !(rand_idx >= QUIET_LO && rand_idx < QUIET_HI)
                    && $urandom_range(0, 99) < 16)
                    gap = $urandom_range(1, 6);
            end

            if (!presenting && items_sent < total_items)
            begin
                if (gap > 0)
                    gap--;
                else
                begin
                    if (row_idx < table_rows.size())
                    begin
                        cur = table_rows[row_idx];
                        row_idx++;
                    end
                    else
                    begin
                        cur = random_item();
                        rand_idx++;
                    end
                    presenting = 1'b1;
                end
            end

            if (presenting)
            begin
                start <= 1'b1;
                mode  <= cur.op;
                value <= cur.key;
            end
            else
            begin
                start <= 1'b0;
                mode  <= 2'($urandom);
                value <= $urandom;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        // empty queue
        add_row(MODE_PEEK,   0,       1'b1, '{1'b0, 32'sd0, 1'b0, 5'd0, 1'b0});
        add_row(MODE_REMOVE, 5,       1'b1, '{1'b0, 32'sd0, 1'b0, 5'd0, 1'b0});
        add_row(MODE_FIND,   KEY_MIN, 1'b1, '{1'b0, 32'sd0, 1'b0, 5'd0, 1'b0});
        // extremes
        add_row(MODE_INSERT, KEY_MAX, 1'b1, '{1'b1, KEY_MAX, 1'b1, 5'd1, 1'b0});
        add_row(MODE_INSERT, KEY_MIN, 1'b1, '{1'b1, KEY_MAX, 1'b1, 5'd2, 1'b0});
        add_row(MODE_FIND,   KEY_MIN, 1'b0, '0);
        // equal keys, absent key
        add_row(MODE_INSERT, 5,       1'b0, '0);
        add_row(MODE_INSERT, 5,       1'b0, '0);
        add_row(MODE_REMOVE, -1,      1'b0, '0);
        // fill to capacity
        add_row(MODE_INSERT, 0,       1'b0, '0);
        add_row(MODE_INSERT, -1,      1'b0, '0);
        add_row(MODE_INSERT, 3,       1'b0, '0);
        add_row(MODE_INSERT, 3,       1'b0, '0);
        add_row(MODE_INSERT, -7,      1'b0, '0);
        add_row(MODE_INSERT, 100,     1'b0, '0);
        add_row(MODE_INSERT, -100,    1'b0, '0);
        add_row(MODE_INSERT, 8,       1'b0, '0);
        add_row(MODE_INSERT, 1,       1'b0, '0);
        add_row(MODE_INSERT, 2,       1'b0, '0);
        add_row(MODE_INSERT, -2,      1'b0, '0);
        add_row(MODE_INSERT, 9,       1'b0, '0);
        // insert when full is refused
        add_row(MODE_INSERT, 4,       1'b1, '{1'b0, KEY_MAX, 1'b1, 5'd16, 1'b1});
        // duplicates: only one removed
        add_row(MODE_REMOVE, 5,       1'b0, '0);
        add_row(MODE_FIND,   5,       1'b0, '0);
        add_row(MODE_REMOVE, KEY_MAX, 1'b0, '0);
        add_row(MODE_REMOVE, KEY_MIN, 1'b0, '0);
        add_row(MODE_PEEK,   0,       1'b0, '0);
        total_items = table_rows.size() + RANDOM_ITEMS;

        while (items_sent < total_items)
            @(posedge clk);
        while (status_fifo.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
